@@ src/psd_pkg.sv @@
// ----------------------------------------------------------------------------
// psd_pkg
// Widths, case codes and stage-to-stage payload types of the point to
// segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  // Coordinates and scaling
  localparam int COORD_W   = 16;
  localparam int FRAC_BITS = 8;
  localparam int SCALE_W   = 2 * FRAC_BITS;
  localparam int NUM_COORD = 9;
  localparam int S_DATA_W  = NUM_COORD * COORD_W;

  // Intermediate widths
  localparam int DIFF_W  = COORD_W + 1;       // coordinate difference
  localparam int PROD_W  = 2 * DIFF_W;        // product of two differences
  localparam int NUM_W   = PROD_W + 1;        // dot(AC, AB), signed
  localparam int SQ_W    = 2 * COORD_W + 2;   // squared length, unsigned
  localparam int CROSS_W = PROD_W;            // cross product component
  localparam int XMAG_W  = CROSS_W - 1;       // its magnitude
  localparam int XSQ_W   = 2 * XMAG_W;        // its square
  localparam int N_W     = XSQ_W + 2;         // sum of three squares
  localparam int Q_W     = SQ_W + SCALE_W;    // scaled squared distance
  localparam int ROOT_W  = Q_W / 2;           // root of it
  localparam int REM_W   = ROOT_W + 1;        // root remainder

  // Output bus
  localparam int DIST_W   = 25;
  localparam int M_DATA_W = 32;
  localparam int CASE_W   = 2;

  // Nearest-point cases
  localparam logic [CASE_W-1:0] CASE_INTERIOR = 2'd0;
  localparam logic [CASE_W-1:0] CASE_START    = 2'd1;
  localparam logic [CASE_W-1:0] CASE_END      = 2'd2;
  localparam logic [CASE_W-1:0] CASE_ZERO     = 2'd3;

  // Divider request: floor(n * 2^SCALE_W / d)
  typedef struct packed {
    logic [N_W-1:0]    n;
    logic [SQ_W-1:0]   d;
    logic [CASE_W-1:0] kind;
  } div_req_t;

  // Root request: floor(sqrt(q))
  typedef struct packed {
    logic [Q_W-1:0]    q;
    logic [CASE_W-1:0] kind;
  } root_req_t;

  // Final result
  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic [CASE_W-1:0] kind;
  } result_t;

endpackage

@@ src/psd_front.sv @@
// ----------------------------------------------------------------------------
// psd_front
// Six-stage front end: differences, products, dot and cross sums, case
// decision, cross squares and selection of dividend and divisor.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [psd_pkg::S_DATA_W-1:0] in_data,
  output logic                       out_valid,
  output psd_pkg::div_req_t          out_req
);
  import psd_pkg::*;

  logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz, cx, cy, cz;

  // Stage 1 registers
  logic                     v1;
  logic signed [DIFF_W-1:0] abx, aby, abz, acx, acy, acz, bcx, bcy, bcz;
  // Stage 2 registers
  logic                     v2;
  logic signed [PROD_W-1:0] pn0, pn1, pn2, pd0, pd1, pd2;
  logic signed [PROD_W-1:0] pa0, pa1, pa2, pb0, pb1, pb2;
  logic signed [PROD_W-1:0] pc0, pc1, pc2, pc3, pc4, pc5;
  // Stage 3 registers
  logic                      v3;
  logic signed [NUM_W-1:0]   num;
  logic [SQ_W-1:0]           den, sq_a, sq_b;
  logic signed [CROSS_W-1:0] xx, xy, xz;
  // Stage 4 registers
  logic                      v4;
  logic [CASE_W-1:0]         kind4;
  logic [SQ_W-1:0]           den4, sq_end4;
  logic [XMAG_W-1:0]         mx, my, mz;
  // Stage 5 registers
  logic                      v5;
  logic [CASE_W-1:0]         kind5;
  logic [SQ_W-1:0]           den5, sq_end5;
  logic [XSQ_W-1:0]          sx, sy, sz;

  logic [CASE_W-1:0]         kind_next;
  logic [N_W-1:0]            cross_sum;

  // Unpack coordinates, a_x in the lowest bits
  assign ax = in_data[0*COORD_W +: COORD_W];
  assign ay = in_data[1*COORD_W +: COORD_W];
  assign az = in_data[2*COORD_W +: COORD_W];
  assign bx = in_data[3*COORD_W +: COORD_W];
  assign by = in_data[4*COORD_W +: COORD_W];
  assign bz = in_data[5*COORD_W +: COORD_W];
  assign cx = in_data[6*COORD_W +: COORD_W];
  assign cy = in_data[7*COORD_W +: COORD_W];
  assign cz = in_data[8*COORD_W +: COORD_W];

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  // Stage 1: edge vectors
  always_ff @(posedge clk) begin
    if (en) begin
      abx <= DIFF_W'(bx) - DIFF_W'(ax);
      aby <= DIFF_W'(by) - DIFF_W'(ay);
      abz <= DIFF_W'(bz) - DIFF_W'(az);
      acx <= DIFF_W'(cx) - DIFF_W'(ax);
      acy <= DIFF_W'(cy) - DIFF_W'(ay);
      acz <= DIFF_W'(cz) - DIFF_W'(az);
      bcx <= DIFF_W'(cx) - DIFF_W'(bx);
      bcy <= DIFF_W'(cy) - DIFF_W'(by);
      bcz <= DIFF_W'(cz) - DIFF_W'(bz);
    end
  end

  // Stage 2: the products for the dot, length and cross sums, in parallel
  always_ff @(posedge clk) begin
    if (en) begin
      pn0 <= acx * abx;
      pn1 <= acy * aby;
      pn2 <= acz * abz;
      pd0 <= abx * abx;
      pd1 <= aby * aby;
      pd2 <= abz * abz;
      pa0 <= acx * acx;
      pa1 <= acy * acy;
      pa2 <= acz * acz;
      pb0 <= bcx * bcx;
      pb1 <= bcy * bcy;
      pb2 <= bcz * bcz;
      pc0 <= acy * abz;
      pc1 <= acz * aby;
      pc2 <= acz * abx;
      pc3 <= acx * abz;
      pc4 <= acx * aby;
      pc5 <= acy * abx;
    end
  end

  // Stage 3: dot products, squared lengths, cross components
  always_ff @(posedge clk) begin
    if (en) begin
      num  <= NUM_W'(pn0) + NUM_W'(pn1) + NUM_W'(pn2);
      den  <= SQ_W'(pd0[PROD_W-3:0]) + SQ_W'(pd1[PROD_W-3:0])
            + SQ_W'(pd2[PROD_W-3:0]);
      sq_a <= SQ_W'(pa0[PROD_W-3:0]) + SQ_W'(pa1[PROD_W-3:0])
            + SQ_W'(pa2[PROD_W-3:0]);
      sq_b <= SQ_W'(pb0[PROD_W-3:0]) + SQ_W'(pb1[PROD_W-3:0])
            + SQ_W'(pb2[PROD_W-3:0]);
      xx   <= pc0 - pc1;
      xy   <= pc2 - pc3;
      xz   <= pc4 - pc5;
    end
  end

  // Stage 4: pick the nearest feature, take cross magnitudes
  always_comb begin
    if (den == '0) begin
      kind_next = CASE_ZERO;
    end else if (num <= 0) begin
      kind_next = CASE_START;
    end else if (num >= $signed({1'b0, den})) begin
      kind_next = CASE_END;
    end else begin
      kind_next = CASE_INTERIOR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind4   <= kind_next;
      den4    <= den;
      sq_end4 <= (kind_next == CASE_END) ? sq_b : sq_a;
      mx      <= xx[CROSS_W-1] ? XMAG_W'(-xx) : XMAG_W'(xx);
      my      <= xy[CROSS_W-1] ? XMAG_W'(-xy) : XMAG_W'(xy);
      mz      <= xz[CROSS_W-1] ? XMAG_W'(-xz) : XMAG_W'(xz);
    end
  end

  // Stage 5: square the cross components
  always_ff @(posedge clk) begin
    if (en) begin
      kind5   <= kind4;
      den5    <= den4;
      sq_end5 <= sq_end4;
      sx      <= mx * mx;
      sy      <= my * my;
      sz      <= mz * mz;
    end
  end

  // Stage 6: dividend and divisor for the chosen case
  assign cross_sum = N_W'(sx) + N_W'(sy) + N_W'(sz);

  always_ff @(posedge clk) begin
    if (en) begin
      out_req.kind <= kind5;
      if (kind5 == CASE_INTERIOR) begin
        out_req.n <= cross_sum;
        out_req.d <= den5;
      end else begin
        out_req.n <= N_W'(sq_end5);
        out_req.d <= SQ_W'(1);
      end
    end
  end

endmodule

@@ src/psd_div.sv @@
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage, Q_W stages.
// Gives floor(n * 2^SCALE_W / d); the quotient is known to fit Q_W bits.
// ----------------------------------------------------------------------------
module psd_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  psd_pkg::div_req_t  in_req,
  output logic               out_valid,
  output psd_pkg::root_req_t out_req
);
  import psd_pkg::*;

  logic              v    [Q_W];
  logic [SQ_W-1:0]   rem  [Q_W];
  logic [Q_W-1:0]    word [Q_W];
  logic [SQ_W-1:0]   dvs  [Q_W];
  logic [CASE_W-1:0] kind [Q_W];

  genvar i;
  generate
    for (i = 0; i < Q_W; i++) begin : g_stage
      logic              src_v;
      logic [SQ_W-1:0]   src_rem;
      logic [Q_W-1:0]    src_word;
      logic [SQ_W-1:0]   src_d;
      logic [CASE_W-1:0] src_kind;
      logic [SQ_W:0]     trial;
      logic [SQ_W:0]     diff;
      logic              ge;

      // Stage input: the request itself or the previous stage
      if (i == 0) begin : g_first
        assign src_v    = in_valid;
        assign src_rem  = in_req.n[N_W-1 -: SQ_W];
        assign src_word = {in_req.n[N_W-SQ_W-1:0], SCALE_W'(0)};
        assign src_d    = in_req.d;
        assign src_kind = in_req.kind;
      end else begin : g_next
        assign src_v    = v[i-1];
        assign src_rem  = rem[i-1];
        assign src_word = word[i-1];
        assign src_d    = dvs[i-1];
        assign src_kind = kind[i-1];
      end

      // Shift in one dividend bit, subtract when it fits
      assign trial = {src_rem, src_word[Q_W-1]};
      assign diff  = trial - {1'b0, src_d};
      assign ge    = (trial >= {1'b0, src_d});

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en) begin
          v[i] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[i]  <= ge ? diff[SQ_W-1:0] : trial[SQ_W-1:0];
          word[i] <= {src_word[Q_W-2:0], ge};
          dvs[i]  <= src_d;
          kind[i] <= src_kind;
        end
      end
    end
  endgenerate

  assign out_valid    = v[Q_W-1];
  assign out_req.q    = word[Q_W-1];
  assign out_req.kind = kind[Q_W-1];

endmodule

@@ src/psd_sqrt.sv @@
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// ROOT_W stages. The last stage is the block's output register.
// ----------------------------------------------------------------------------
module psd_sqrt (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  psd_pkg::root_req_t in_req,
  output logic               out_valid,
  output psd_pkg::result_t   out_res
);
  import psd_pkg::*;

  logic              v    [ROOT_W];
  logic [REM_W-1:0]  rem  [ROOT_W];
  logic [Q_W-1:0]    word [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [CASE_W-1:0] kind [ROOT_W];

  genvar j;
  generate
    for (j = 0; j < ROOT_W; j++) begin : g_stage
      logic              src_v;
      logic [REM_W-1:0]  src_rem;
      logic [Q_W-1:0]    src_word;
      logic [ROOT_W-1:0] src_root;
      logic [CASE_W-1:0] src_kind;
      logic [REM_W+1:0]  acc;
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  diff;
      logic              ge;

      // Stage input: the request itself or the previous stage
      if (j == 0) begin : g_first
        assign src_v    = in_valid;
        assign src_rem  = '0;
        assign src_word = in_req.q;
        assign src_root = '0;
        assign src_kind = in_req.kind;
      end else begin : g_next
        assign src_v    = v[j-1];
        assign src_rem  = rem[j-1];
        assign src_word = word[j-1];
        assign src_root = root[j-1];
        assign src_kind = kind[j-1];
      end

      // Bring down two bits, try root digit one
      assign acc   = {src_rem, src_word[Q_W-1 -: 2]};
      assign trial = {1'b0, src_root, 2'b01};
      assign diff  = acc - trial;
      assign ge    = (acc >= trial);

      always_ff @(posedge clk) begin
        if (rst) begin
          v[j] <= 1'b0;
        end else if (en) begin
          v[j] <= src_v;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem[j]  <= ge ? diff[REM_W-1:0] : acc[REM_W-1:0];
          word[j] <= {src_word[Q_W-3:0], 2'b00};
          root[j] <= {src_root[ROOT_W-2:0], ge};
          kind[j] <= src_kind;
        end
      end
    end
  endgenerate

  assign out_valid        = v[ROOT_W-1];
  assign out_res.distance = root[ROOT_W-1];
  assign out_res.kind     = kind[ROOT_W-1];

endmodule

@@ src/point_segment_distance_3d.sv @@
// ----------------------------------------------------------------------------
// point_segment_distance_3d
// Distance from a query point to a 3-D segment, in unsigned Q.8.
// ----------------------------------------------------------------------------
// Input stream s_*: one transaction per query, tdata holds a_x, a_y, a_z,
// b_x, b_y, b_z, q_x, q_y, q_z, 16-bit two's complement each, a_x lowest.
// Output stream m_*: one transaction per query in arrival order; tdata
// holds distance_q8 in bits 24:0, tuser the nearest_case code (interior,
// start end, far end, zero-length segment).
// The pipeline has 6 front-end stages (differences, products, sums,
// case pick, cross squares, operand select), 50 divider stages of one
// quotient bit each and 25 root stages of one root bit each; the last
// root stage is the output register.
// Throughput is one transaction per cycle while the receiver takes results. The whole pipeline advances
// together whenever the output register is empty or being taken, so a
// stalled receiver freezes every stage and s_tready drops with it; no
// transaction is lost or repeated.
// Reset clears all valid bits; the block accepts input in the next cycle.
// ----------------------------------------------------------------------------
module point_segment_distance_3d (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [psd_pkg::S_DATA_W-1:0]  s_tdata,  // a_x,a_y,a_z,b_x,b_y,b_z,q_x,q_y,q_z
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [psd_pkg::M_DATA_W-1:0]  m_tdata,  // distance_q8, zero fill
  output logic [psd_pkg::CASE_W-1:0]    m_tuser   // nearest_case
);
  import psd_pkg::*;

  logic      en;
  logic      front_valid;
  div_req_t  front_req;
  logic      div_valid;
  root_req_t div_req;
  result_t   res;

  // Advance every stage when the output slot is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  psd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (front_valid),
    .out_req   (front_req)
  );

  psd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (front_valid),
    .in_req    (front_req),
    .out_valid (div_valid),
    .out_req   (div_req)
  );

  psd_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .in_req    (div_req),
    .out_valid (m_tvalid),
    .out_res   (res)
  );

  // Pack the result
  assign m_tdata = M_DATA_W'(res.distance[DIST_W-1:0]);
  assign m_tuser = res.kind;

  // Pipeline is empty right after reset
  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result presented right after reset");

  // Hold the output transaction while the receiver stalls
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("output changed while stalled");

  // A held output keeps the whole pipeline, and the input, stalled
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while output stalled");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for point_segment_distance_3d: a directed table of
// queries (end cases, extremes, zero-length segments) followed by random
// queries, with random idling on both streams and one long output stall.
// Every output transaction is checked against a typed result or an in-bench distance model.
// ----------------------------------------------------------------------------
module tb_top;
  import psd_pkg::*;

  localparam int NUM_RANDOM  = 580;
  localparam int IDLE_PCT    = 24;
  localparam int DRAIN_CYC   = 120;
  localparam int STALL_CYC   = 400;
  localparam int STALL_AFTER = 150;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t query_t [NUM_COORD];

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic [CASE_W-1:0] kind;
  } dist_result_t;

  typedef struct {
    int          c [NUM_COORD];
    bit          typed;
    int          distance;
    logic [1:0]  kind;
  } query_row_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_DATA_W-1:0]  s_tdata;  // a_x,a_y,a_z,b_x,b_y,b_z,q_x,q_y,q_z
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_DATA_W-1:0]  m_tdata;  // distance_q8, zero fill
  logic [CASE_W-1:0]    m_tuser;  // nearest_case

  dist_result_t pending_results [$];
  int           num_errors = 0;
  int           num_accepted = 0;
  bit           stim_done = 0;
  bit           burst_mode = 0;

  point_segment_distance_3d dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Directed queries; typed results only where they are obvious
  query_row_t directed [] = '{
    '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1, 0, CASE_ZERO},
    '{'{0, 0, 0, 0, 0, 0, 3, 4, 0}, 1, 1280, CASE_ZERO},
    '{'{0, 0, 0, 10, 0, 0, -3, 4, 0}, 1, 1280, CASE_START},
    '{'{0, 0, 0, 10, 0, 0, 13, 4, 0}, 1, 1280, CASE_END},
    '{'{0, 0, 0, 10, 0, 0, 5, 3, 0}, 1, 768, CASE_INTERIOR},
    '{'{0, 0, 0, 10, 0, 0, 0, 5, 0}, 1, 1280, CASE_START},
    '{'{0, 0, 0, 10, 0, 0, 10, 5, 0}, 1, 1280, CASE_END},
    '{'{0, 0, 0, 0, 0, 10, 4, 3, 5}, 1, 1280, CASE_INTERIOR},
    '{'{0, 0, 0, 0, 10, 0, 3, 5, 4}, 1, 1280, CASE_INTERIOR},
    '{'{-32768, -32768, -32768, 32767, 32767, 32767, -32768, -32768, -32768},
      1, 0, CASE_START},
    '{'{-32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767},
      1, 0, CASE_END},
    '{'{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767},
      0, 0, CASE_ZERO},
    '{'{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768},
      0, 0, CASE_ZERO},
    '{'{-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767},
      0, 0, CASE_INTERIOR},
    '{'{-32768, 32767, -32768, 32767, -32768, 32767, 0, 0, 0}, 0, 0, CASE_INTERIOR},
    '{'{32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767}, 0, 0, CASE_INTERIOR},
    '{'{-1, -1, -1, 0, 0, 0, -32768, 32767, -32768}, 0, 0, CASE_INTERIOR},
    '{'{1, 2, 3, 4, 6, 8, 100, -200, 300}, 0, 0, CASE_INTERIOR},
    '{'{-32768, 0, 0, 32767, 0, 0, 0, 32767, 32767}, 0, 0, CASE_INTERIOR},
    '{'{0, 0, 0, 1, 1, 1, 1, 0, 0}, 0, 0, CASE_INTERIOR}
  };

  // Floor of the integer square root
  function automatic logic [63:0] isqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] one;
    res = 0;
    one = 64'h1 << 62;
    while (one > v) one = one >> 2;
    while (one != 0) begin
      if (v >= res + one) begin
        v   = v - (res + one);
        res = (res >> 1) + one;
      end else begin
        res = res >> 1;
      end
      one = one >> 2;
    end
    return res;
  endfunction

  function automatic logic [127:0] sq_mag(input longint v);
    logic [127:0] m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  // Predict distance and nearest case for one query
  function automatic dist_result_t segment_distance(input query_t q);
    longint abx, aby, abz, acx, acy, acz, num, den;
    longint crx, cry, crz;
    logic [127:0] n, d, scaled;
    dist_result_t r;
    abx = longint'(q[3]) - q[0];
    aby = longint'(q[4]) - q[1];
    abz = longint'(q[5]) - q[2];
    acx = longint'(q[6]) - q[0];
    acy = longint'(q[7]) - q[1];
    acz = longint'(q[8]) - q[2];
    num = acx * abx + acy * aby + acz * abz;
    den = abx * abx + aby * aby + abz * abz;
    d = 1;
    if (den == 0) begin
      r.kind = CASE_ZERO;
      n = sq_mag(acx) + sq_mag(acy) + sq_mag(acz);
    end else if (num <= 0) begin
      r.kind = CASE_START;
      n = sq_mag(acx) + sq_mag(acy) + sq_mag(acz);
    end else if (num >= den) begin
      r.kind = CASE_END;
      n = sq_mag(longint'(q[6]) - q[3]) + sq_mag(longint'(q[7]) - q[4]) +
          sq_mag(longint'(q[8]) - q[5]);
    end else begin
      r.kind = CASE_INTERIOR;
      crx = acy * abz - acz * aby;
      cry = acz * abx - acx * abz;
      crz = acx * aby - acy * abx;
      n = sq_mag(crx) + sq_mag(cry) + sq_mag(crz);
      d = den;
    end
    scaled = (n << SCALE_W) / d;
    r.distance = DIST_W'(isqrt(scaled[63:0]));
    return r;
  endfunction

  function automatic coord_t pick_coord(input int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(100) - 50);
      default: begin
        case ($urandom_range(3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return -1;
        endcase
      end
    endcase
  endfunction

  // Random query: full range, small, corner values, zero-length, on ends
  function automatic void random_query(output query_t q);
    int mode;
    int shape;
    mode  = $urandom_range(2);
    shape = $urandom_range(9);
    for (int i = 0; i < NUM_COORD; i++) q[i] = pick_coord(mode);
    if (shape == 0) begin
      for (int i = 0; i < 3; i++) q[3+i] = q[i];
    end else if (shape == 1) begin
      for (int i = 0; i < 3; i++) q[6+i] = q[$urandom_range(1) * 3 + i];
    end
  endfunction

  // Drive one query and wait for its handshake
  task automatic send_query(input query_t q, input bit typed,
                            input dist_result_t typed_res);
    logic [S_DATA_W-1:0] word;
    while (!burst_mode && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    for (int i = 0; i < NUM_COORD; i++) word[i*COORD_W +: COORD_W] = q[i];
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_results.push_back(typed ? typed_res : segment_distance(q));
    num_accepted++;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset and stimulus
  initial begin
    query_t       q;
    dist_result_t tr;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[k]) begin
      for (int i = 0; i < NUM_COORD; i++) q[i] = coord_t'(directed[k].c[i]);
      tr.distance = DIST_W'(directed[k].distance);
      tr.kind     = directed[k].kind;
      send_query(q, directed[k].typed, tr);
    end
    for (int k = 0; k < NUM_RANDOM; k++) begin
      burst_mode = (k >= 300 && k < 420);
      random_query(q);
      send_query(q, 1'b0, tr);
    end
    burst_mode = 0;
    s_tvalid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: random back-pressure plus one long hold-off
  initial begin
    bit stalled;
    stalled = 0;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!stalled && num_accepted >= STALL_AFTER) begin
        stalled = 1;
        m_tready <= 1'b0;
        repeat (STALL_CYC) @(posedge clk);
      end
      m_tready <= burst_mode || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check each output transaction against the oldest prediction
  always @(posedge clk) begin
    dist_result_t exp_res;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected output: distance_q8=%0d nearest_case=%0d",
               m_tdata[DIST_W-1:0], m_tuser);
        num_errors++;
      end else begin
        exp_res = pending_results.pop_front();
        if (m_tdata[DIST_W-1:0] !== exp_res.distance) begin
          $error("distance_q8: expected %0d, actual %0d", exp_res.distance,
                 m_tdata[DIST_W-1:0]);
          num_errors++;
        end
        if (m_tuser !== exp_res.kind) begin
          $error("nearest_case: expected %0d, actual %0d", exp_res.kind, m_tuser);
          num_errors++;
        end
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (num_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sim.f @@
src/psd_pkg.sv
src/psd_front.sv
src/psd_div.sv
src/psd_sqrt.sv
src/point_segment_distance_3d.sv
tb/sv/tb_top.sv
